// ----- sv/duplicate_within_window_detector_defines.svh -----
// Assertion macros used by the checker of the duplicate detector.
`ifndef DUPLICATE_WITHIN_WINDOW_DETECTOR_DEFINES_SVH
`define DUPLICATE_WITHIN_WINDOW_DETECTOR_DEFINES_SVH

// Checked on every clock edge outside reset.
`define DWD_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("duplicate detector check failed");

// Checked on every clock edge, reset included.
`define DWD_ASSERT_RST(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("duplicate detector reset check failed");

`endif

// ----- sv/dwd_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package dwd_pkg;
  localparam int DataW = 32;
  localparam int WinW = 7;
  localparam int MaxWindowDefault = 64;
  localparam logic [WinW-1:0] WindowLenReset = 7'd3;
  localparam int OutW = 8;
endpackage

`default_nettype wire

// ----- sv/dwd_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none

module dwd_cell #(
  parameter int IDX = 0
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        shift,
  input  wire logic                        clear,
  input  wire logic [dwd_pkg::DataW-1:0]   probe,
  input  wire logic [dwd_pkg::WinW-1:0]    window_len,
  input  wire logic [dwd_pkg::DataW-1:0]   prev_value,
  input  wire logic                        prev_valid,
  output logic      [dwd_pkg::DataW-1:0]   value,
  output logic                             valid,
  output logic                             match
);
  import dwd_pkg::*;

  localparam logic [31:0] Pos = 32'(IDX);

  logic in_window;

  // The cell holds the value that is IDX+1 items old, so it counts while its
  // position is below the window length.
  assign in_window = Pos < {{(32 - WinW){1'b0}}, window_len};

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (shift) begin
      valid <= prev_valid && ((IDX == 0) || !clear);
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      value <= prev_value;
      match <= valid && in_window && !clear && (value == probe);
    end
  end
endmodule

`default_nettype wire

// ----- sv/duplicate_within_window_detector.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake          Payload
// s_*       in         s_tvalid/s_tready  tdata = value, tuser = start_req
// m_*       out        m_tvalid/m_tready  tdata = duplicate, any_duplicate
// cfg_*     in         cfg_we             cfg_wdata = window_len
//
// One input transaction is taken per clock cycle when the output side keeps up.
// The pipeline runs through the row of compare cells, then the match reduction
// and sticky flag register, which also serves as the output register.
// rst is synchronous and active high; it clears the cell valid bits, the
// sticky flag, both pipeline stages, and sets window_len to 3.
// A stalled output holds its transaction and stops intake only once the
// compare stage is also full.

module duplicate_within_window_detector #(
  parameter int MAX_WINDOW = dwd_pkg::MaxWindowDefault
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  // Input stream. tdata: [31:0] value (two's complement).
  input  wire logic                       s_tvalid,
  output logic                            s_tready,
  input  wire logic [dwd_pkg::DataW-1:0]  s_tdata,
  // tuser: [0] start_req, begins a new sequence and clears the history.
  input  wire logic                       s_tuser,
  // Output stream. tdata: [0] duplicate, [1] any_duplicate, [7:2] zero.
  output logic                            m_tvalid,
  input  wire logic                       m_tready,
  output logic      [dwd_pkg::OutW-1:0]   m_tdata,
  // Configuration: window_len write.
  input  wire logic                       cfg_we,
  input  wire logic [dwd_pkg::WinW-1:0]   cfg_wdata
);
  import dwd_pkg::*;

  logic [WinW-1:0]  window_len;
  logic             accept;
  logic             advance;
  logic             s1_valid;
  logic             s1_start;
  logic             dup_any;
  logic             duplicate;
  logic             any_duplicate;
  logic             any_duplicate_next;

  logic [DataW-1:0]      chain_value [MAX_WINDOW];
  logic [MAX_WINDOW-1:0] chain_valid;
  logic [MAX_WINDOW-1:0] match_bits;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_len <= WindowLenReset;
    end else if (cfg_we) begin
      window_len <= cfg_wdata;
    end
  end

  // The output register frees up when it is empty or being taken; the compare
  // stage can accept whenever it is empty or moving forward.
  assign advance  = !m_tvalid || m_tready;
  assign s_tready = !s1_valid || advance;
  assign accept   = s_tvalid && s_tready;

  // Row of cells: cell 0 holds the newest stored value. On every accepted
  // transaction each cell compares its value against the incoming one and then
  // takes its neighbor's value, so the chain shifts by one position.
  for (genvar g = 0; g < MAX_WINDOW; g++) begin : g_cell
    if (g == 0) begin : g_head
      dwd_cell #(.IDX(g)) u_cell (
        .clk        (clk),
        .rst        (rst),
        .shift      (accept),
        .clear      (s_tuser),
        .probe      (s_tdata),
        .window_len (window_len),
        .prev_value (s_tdata),
        .prev_valid (1'b1),
        .value      (chain_value[g]),
        .valid      (chain_valid[g]),
        .match      (match_bits[g])
      );
    end else begin : g_body
      dwd_cell #(.IDX(g)) u_cell (
        .clk        (clk),
        .rst        (rst),
        .shift      (accept),
        .clear      (s_tuser),
        .probe      (s_tdata),
        .window_len (window_len),
        .prev_value (chain_value[g-1]),
        .prev_valid (chain_valid[g-1]),
        .value      (chain_value[g]),
        .valid      (chain_valid[g]),
        .match      (match_bits[g])
      );
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_start <= s_tuser;
    end
  end

  // Match bits were registered in the cells; here they are reduced and the
  // sticky flag is updated, restarting on a sequence start.
  assign dup_any            = |match_bits;
  assign any_duplicate_next = (any_duplicate && !s1_start) || dup_any;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid      <= 1'b0;
      any_duplicate <= 1'b0;
    end else if (advance) begin
      m_tvalid <= s1_valid;
      if (s1_valid) begin
        any_duplicate <= any_duplicate_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid) begin
      duplicate <= dup_any;
    end
  end

  assign m_tdata = {{(OutW - 2){1'b0}}, any_duplicate, duplicate};
endmodule

`default_nettype wire

// ----- sv/dwd_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

`include "duplicate_within_window_detector_defines.svh"

module dwd_checker (
  input wire logic                       clk,
  input wire logic                       rst,
  input wire logic                       s_tvalid,
  input wire logic                       s_tready,
  input wire logic                       m_tvalid,
  input wire logic                       m_tready,
  input wire logic [dwd_pkg::OutW-1:0]   m_tdata
);
  import dwd_pkg::*;

  // A duplicate on this transaction always raises the sticky flag with it.
  `DWD_ASSERT(a_dup_sets_sticky, m_tvalid && m_tdata[0] |-> m_tdata[1])

  // The padding bits of the result stay zero.
  `DWD_ASSERT(a_pad_zero, m_tvalid |-> (m_tdata[OutW-1:2] == '0))

  // A stalled result is held unchanged.
  `DWD_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))

  // Reset leaves no result pending.
  `DWD_ASSERT_RST(a_reset_empty, rst |=> !m_tvalid)

  // A result that appears on an idle output stems from an earlier input transaction.
  `DWD_ASSERT(a_no_invent, !m_tvalid ##1 m_tvalid |-> $past(s_tvalid && s_tready, 2))
endmodule

bind duplicate_within_window_detector dwd_checker u_dwd_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire

// ----- test/duplicate_within_window_detector_test.sv -----
`timescale 1ns / 1ps

module duplicate_within_window_detector_test;
  import dwd_pkg::*;

  localparam int MaxWin = MaxWindowDefault;
  // The receiver holds off this long at least once, well past the two pipeline stages.
  localparam int LongHold = 200;
  // Cycles with no transaction on either side before the run is declared hung.
  localparam int StallLimit = 2000;
  localparam int PhaseCount = 12;
  localparam int PhaseItems = 150;

  typedef enum bit {
    ROW_ITEM,
    ROW_CFG
  } row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    logic [6:0]  win;
    logic [31:0] value;
    logic        start;
    bit          typed;
    logic        dup;
    logic        any;
  } plan_row_t;

  typedef struct packed {
    logic dup;
    logic any;
  } match_flags_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [DataW-1:0]      s_tdata = '0;
  logic                  s_tuser = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OutW-1:0]       m_tdata;
  logic                  cfg_we = 1'b0;
  logic [WinW-1:0]       cfg_wdata = '0;

  // Predictor state: the current sequence as the block should hold it.
  logic [31:0]    seq_history [MaxWin];
  int             seq_slot = 0;
  int             seq_fill = 0;
  logic           seq_seen = 1'b0;
  logic [WinW-1:0] window_setting = WindowLenReset;

  match_flags_t   pending_flags [$];
  int             mismatches = 0;
  int             results_seen = 0;
  int             stall_cycles = 0;

  // Side information for the item currently offered by the sender. A typed row
  // carries its own expectation; every other item is checked against the predictor.
  bit             row_typed = 1'b0;
  logic           row_dup = 1'b0;
  logic           row_any = 1'b0;

  // Idling controls shared between the stimulus sequence and the receiver.
  bit             send_idle_on = 1'b0;
  bit             recv_idle_on = 1'b0;
  bit             hold_req = 1'b0;

  // Directed part. Window is 3 out of reset, and the first rows carry no start
  // mark, so they also cover a sequence that begins implicitly after reset.
  plan_row_t directed_plan [22] = '{
    '{ROW_ITEM, 7'd0,   32'h0000_0000, 1'b0, 1'b1, 1'b0, 1'b0},
    '{ROW_ITEM, 7'd0,   32'h0000_0000, 1'b0, 1'b1, 1'b1, 1'b1},
    '{ROW_ITEM, 7'd0,   32'h7FFF_FFFF, 1'b0, 1'b1, 1'b0, 1'b1},
    '{ROW_ITEM, 7'd0,   32'h8000_0000, 1'b0, 1'b1, 1'b0, 1'b1},
    '{ROW_ITEM, 7'd0,   32'hFFFF_FFFF, 1'b0, 1'b1, 1'b0, 1'b1},
    '{ROW_ITEM, 7'd0,   32'h8000_0000, 1'b0, 1'b1, 1'b1, 1'b1},
    // A start mark clears the history and the sticky flag first.
    '{ROW_ITEM, 7'd0,   32'h7FFF_FFFF, 1'b1, 1'b1, 1'b0, 1'b0},
    '{ROW_ITEM, 7'd0,   32'h7FFF_FFFF, 1'b0, 1'b1, 1'b1, 1'b1},
    '{ROW_ITEM, 7'd0,   32'h0000_0001, 1'b0, 1'b1, 1'b0, 1'b1},
    '{ROW_ITEM, 7'd0,   32'h0000_0002, 1'b0, 1'b1, 1'b0, 1'b1},
    '{ROW_ITEM, 7'd0,   32'h0000_0003, 1'b0, 1'b1, 1'b0, 1'b1},
    // Four back is just outside a window of three.
    '{ROW_ITEM, 7'd0,   32'h7FFF_FFFF, 1'b0, 1'b1, 1'b0, 1'b1},
    // A zero window never matches, though values are still stored.
    '{ROW_CFG,  7'd0,   32'h0,         1'b0, 1'b0, 1'b0, 1'b0},
    '{ROW_ITEM, 7'd0,   32'h0000_0003, 1'b1, 1'b1, 1'b0, 1'b0},
    '{ROW_ITEM, 7'd0,   32'h0000_0003, 1'b0, 1'b1, 1'b0, 1'b0},
    // The new length applies to the history already held.
    '{ROW_CFG,  7'd1,   32'h0,         1'b0, 1'b0, 1'b0, 1'b0},
    '{ROW_ITEM, 7'd0,   32'h0000_0003, 1'b0, 1'b1, 1'b1, 1'b1},
    // Oversized window acts as the full ring.
    '{ROW_CFG,  7'd127, 32'h0,         1'b0, 1'b0, 1'b0, 1'b0},
    '{ROW_ITEM, 7'd0,   32'h0000_0003, 1'b0, 1'b0, 1'b0, 1'b0},
    '{ROW_CFG,  7'd64,  32'h0,         1'b0, 1'b0, 1'b0, 1'b0},
    '{ROW_ITEM, 7'd0,   32'h8000_0000, 1'b1, 1'b0, 1'b0, 1'b0},
    '{ROW_ITEM, 7'd0,   32'h8000_0000, 1'b0, 1'b0, 1'b0, 1'b0}
  };

  duplicate_within_window_detector #(
    .MAX_WINDOW(MaxWin)
  ) dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  // Steps the predicted sequence state by one value and returns the flags that
  // the block should report for it.
  function automatic match_flags_t predict_match(input logic [31:0] v, input logic start);
    match_flags_t flags;
    int span;
    int i;
    int pos;
    flags = '0;
    if (start) begin
      seq_slot = 0;
      seq_fill = 0;
      seq_seen = 1'b0;
    end
    span = (window_setting > MaxWin) ? MaxWin : int'(window_setting);
    if (span > seq_fill) span = seq_fill;
    for (i = 0; i < span; i++) begin
      pos = (seq_slot + MaxWin - 1 - i) % MaxWin;
      if (seq_history[pos] == v) flags.dup = 1'b1;
    end
    seq_history[seq_slot] = v;
    seq_slot = (seq_slot + 1) % MaxWin;
    if (seq_fill < MaxWin) seq_fill++;
    seq_seen = seq_seen | flags.dup;
    flags.any = seq_seen;
    return flags;
  endfunction

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= 10) $display("%0t: %s", $time, what);
  endtask

  // Output check first, then the register write and the input transaction, so
  // an expectation queued at this edge can never meet a result of this edge.
  always @(posedge clk) begin
    match_flags_t want;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        results_seen++;
        if (pending_flags.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with nothing expected, tdata %h",
                                    results_seen, m_tdata));
        end else begin
          want = pending_flags[0];
          pending_flags.delete(0);
          if (m_tdata[0] !== want.dup)
            report_mismatch($sformatf("result %0d duplicate: expected %0b, got %0b",
                                      results_seen, want.dup, m_tdata[0]));
          if (m_tdata[1] !== want.any)
            report_mismatch($sformatf("result %0d any_duplicate: expected %0b, got %0b",
                                      results_seen, want.any, m_tdata[1]));
          if (m_tdata[OutW-1:2] !== '0)
            report_mismatch($sformatf("result %0d padding: expected 0, got %h",
                                      results_seen, m_tdata[OutW-1:2]));
        end
      end
      if (cfg_we) window_setting = cfg_wdata;
      if (s_tvalid && s_tready) begin
        want = predict_match(s_tdata, s_tuser);
        if (row_typed) begin
          want.dup = row_dup;
          want.any = row_any;
        end
        pending_flags.insert(pending_flags.size(), want);
      end
    end
  end

  // Watchdog: any transaction on either side restarts the count.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) stall_cycles = 0;
    else stall_cycles++;
    if (stall_cycles >= StallLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  // Receiver: random stall bursts, plus one long hold-off on request.
  always begin
    @(negedge clk);
    if (hold_req) begin
      hold_req = 1'b0;
      m_tready <= 1'b0;
      repeat (LongHold - 1) @(negedge clk);
    end else if (recv_idle_on && $urandom_range(0, 5) == 0) begin
      m_tready <= 1'b0;
      repeat ($urandom_range(0, 9)) @(negedge clk);
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Offers one item and returns after the edge at which it was taken, or after an idle burst that follows it.
  task automatic send_item(input logic [31:0] v, input logic start, input bit typed,
                           input logic exp_dup, input logic exp_any);
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata <= v;
    s_tuser <= start;
    row_typed = typed;
    row_dup = exp_dup;
    row_any = exp_any;
    do @(posedge clk); while (!(s_tvalid && s_tready));
    if (send_idle_on && $urandom_range(0, 4) == 0) begin
      // Idle burst; the data lines carry junk meanwhile.
      @(negedge clk);
      s_tvalid <= 1'b0;
      s_tdata <= $urandom;
      s_tuser <= 1'($urandom_range(0, 1));
      repeat ($urandom_range(0, 9)) @(negedge clk);
    end
  endtask

  // Stops offering and waits until every expected result has come back.
  task automatic wait_drained();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_flags.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_window(input logic [WinW-1:0] w);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= w;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    logic [31:0] recent [$];
    logic [31:0] v;
    logic        start;
    int          w;
    int          win_eff;
    int          d;
    int          pick;
    int          start_odds;
    int          k;
    int          p;
    int          n;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_idle_on = 1'b1;
    recv_idle_on = 1'b1;
    for (k = 0; k < $size(directed_plan); k++) begin
      if (directed_plan[k].kind == ROW_CFG) begin
        wait_drained();
        write_window(directed_plan[k].win);
      end else begin
        send_item(directed_plan[k].value, directed_plan[k].start, directed_plan[k].typed,
                  directed_plan[k].dup, directed_plan[k].any);
      end
    end

    // Random part: one window setting per phase. Under half of the items repeat a value
    // from a chosen distance back in the current sequence, with the window edge and
    // one past it favored; the rest are fresh random values or corner values.
    for (p = 0; p < PhaseCount; p++) begin
      wait_drained();
      case (p)
        0: w = 3;
        1: w = 0;
        2: w = 64;
        3: w = 1;
        4: w = 127;
        5: w = 65;
        6: w = 2;
        7: w = 63;
        8: w = $urandom_range(0, 127);
        9: w = 5;
        10: w = 64;
        default: w = 16;
      endcase
      write_window(WinW'(w));
      win_eff = (w > MaxWin) ? MaxWin : w;
      start_odds = (p % 2 == 0) ? 300 : 10;
      send_idle_on = (p < PhaseCount - 2) && (p % 4 != 1) && (p != 3);
      recv_idle_on = (p < PhaseCount - 2) && (p % 3 != 2);
      // Long receiver hold-off while the sender keeps offering back to back.
      if (p == 3) hold_req = 1'b1;
      for (n = 0; n < PhaseItems; n++) begin
        start = ($urandom_range(0, start_odds) == 0);
        if (start) recent.delete();
        pick = $urandom_range(0, 99);
        if (pick < 10) d = win_eff;
        else if (pick < 20) d = win_eff + 1;
        else if (pick < 45) d = $urandom_range(1, 70);
        else d = 0;
        if (d >= 1 && d <= recent.size()) begin
          v = recent[recent.size() - d];
        end else if (pick >= 95) begin
          case ($urandom_range(0, 3))
            0: v = 32'h0000_0000;
            1: v = 32'h7FFF_FFFF;
            2: v = 32'h8000_0000;
            default: v = 32'hFFFF_FFFF;
          endcase
        end else begin
          v = $urandom;
        end
        recent.insert(recent.size(), v);
        if (recent.size() > 80) recent.delete(0);
        send_item(v, start, 1'b0, 1'b0, 1'b0);
      end
    end

    wait_drained();
    repeat (4) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+sv
sv/dwd_pkg.sv
sv/dwd_cell.sv
sv/duplicate_within_window_detector.sv
sv/dwd_checker.sv
test/duplicate_within_window_detector_test.sv
